@@ src/kbc_pkg.sv @@
package kbc_pkg;

   // default table depth
   localparam int KBC_ENTRIES = 64;

   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 32;
   localparam int AMOUNT_W = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 32;

   // opcode bits: bit 1 selects read, bit 0 picks received over sent on add
   localparam int OP_READ_BIT = 1;
   localparam int OP_RCVD_BIT = 0;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // which result the datapath builds when the controller loads the response
   typedef enum logic [1:0] {
      RES_HIT   = 2'd0,
      RES_ALLOC = 2'd1,
      RES_FULL  = 2'd2,
      RES_MISS  = 2'd3
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         inc_idx;
      logic         alloc;
      logic         update;
      logic         ld_rsp;
      res_kind_type res_kind;
   } kbc_cmd_type;

   typedef struct packed {
      logic used_zero;
      logic last_idx;
      logic key_match;
      logic full;
      logic is_read;
   } kbc_sts_type;

endpackage

@@ src/kbc_if.sv @@
// request word channel
interface kbc_req_if
   import kbc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [KEY_W-1:0]           user_key;
   logic signed [AMOUNT_W-1:0] byte_amount;

   modport source (output valid, output opcode, output user_key, output byte_amount,
                   input ready);
   modport sink   (input valid, input opcode, input user_key, input byte_amount,
                   output ready);
endinterface

// response word channel
interface kbc_rsp_if
   import kbc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  sent_total;
   logic [TOTAL_W-1:0]  received_total;

   modport source (output valid, output status, output sent_total, output received_total,
                   input ready);
   modport sink   (input valid, input status, input sent_total, input received_total,
                   output ready);
endinterface

@@ src/kbc_datapath.sv @@
module kbc_datapath
   import kbc_pkg::*;
#(
   parameter int ENTRIES = KBC_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kbc_cmd_type                cmd,
   output kbc_sts_type                sts,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [KEY_W-1:0]           req_user_key,
   input  logic signed [AMOUNT_W-1:0] req_byte_amount,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TOTAL_W-1:0]         rsp_sent_total,
   output logic [TOTAL_W-1:0]         rsp_received_total
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // table memories, filled in allocation order
   logic [KEY_W-1:0]   key_mem  [ENTRIES];
   logic [TOTAL_W-1:0] sent_mem [ENTRIES];
   logic [TOTAL_W-1:0] rcvd_mem [ENTRIES];

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    used_ff, used_in;

   logic [KEY_W-1:0]   key_rd_ff;
   logic [TOTAL_W-1:0] sent_rd_ff;
   logic [TOTAL_W-1:0] rcvd_rd_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TOTAL_W-1:0]  sent_tot_ff, sent_tot_in;
   logic [TOTAL_W-1:0]  rcvd_tot_ff, rcvd_tot_in;

   logic               is_read;
   logic               add_rcvd;
   logic [TOTAL_W-1:0] sent_upd;
   logic [TOTAL_W-1:0] rcvd_upd;
   logic [TOTAL_W-1:0] sent_new;
   logic [TOTAL_W-1:0] rcvd_new;
   logic [IDX_W-1:0]   alloc_idx;

   assign is_read   = op_ff[OP_READ_BIT];
   assign add_rcvd  = op_ff[OP_RCVD_BIT];
   assign alloc_idx = used_ff[IDX_W-1:0];

   // item latch and scan index
   always_comb begin
      op_in  = op_ff;
      key_in = key_ff;
      amt_in = amt_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         op_in  = req_opcode;
         key_in = req_user_key;
         amt_in = AMOUNT_W'(unsigned'(req_byte_amount));
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      amt_ff <= amt_in;
      idx_ff <= idx_in;
   end

   // fill count: entries below it are the valid ones
   always_comb begin
      used_in = used_ff;
      if (cmd.alloc) used_in = used_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // counter arithmetic, modulo 2^32
   always_comb begin
      sent_upd = sent_rd_ff;
      rcvd_upd = rcvd_rd_ff;
      sent_new = '0;
      rcvd_new = '0;
      if (!is_read) begin
         if (add_rcvd) begin
            rcvd_upd = rcvd_rd_ff + amt_ff;
            rcvd_new = amt_ff;
         end else begin
            sent_upd = sent_rd_ff + amt_ff;
            sent_new = amt_ff;
         end
      end
   end

   // key memory: allocate write, scan read
   always_ff @(posedge clock) begin
      if (cmd.alloc) key_mem[alloc_idx] <= key_ff;
      key_rd_ff <= key_mem[idx_ff];
   end

   // counter memories: allocate or update write, read at scan index
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         sent_mem[alloc_idx] <= sent_new;
      end else if (cmd.update) begin
         sent_mem[idx_ff] <= sent_upd;
      end
      sent_rd_ff <= sent_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         rcvd_mem[alloc_idx] <= rcvd_new;
      end else if (cmd.update) begin
         rcvd_mem[idx_ff] <= rcvd_upd;
      end
      rcvd_rd_ff <= rcvd_mem[idx_ff];
   end

   // response word
   always_comb begin
      status_in   = status_ff;
      sent_tot_in = sent_tot_ff;
      rcvd_tot_in = rcvd_tot_ff;
      if (cmd.ld_rsp) begin
         case (cmd.res_kind)
            RES_HIT: begin
               status_in   = ST_OK;
               sent_tot_in = sent_upd;
               rcvd_tot_in = rcvd_upd;
            end
            RES_ALLOC: begin
               status_in   = ST_OK;
               sent_tot_in = sent_new;
               rcvd_tot_in = rcvd_new;
            end
            RES_FULL: begin
               status_in   = ST_FULL;
               sent_tot_in = '0;
               rcvd_tot_in = '0;
            end
            default: begin
               status_in   = ST_NOT_FOUND;
               sent_tot_in = '0;
               rcvd_tot_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      sent_tot_ff <= sent_tot_in;
      rcvd_tot_ff <= rcvd_tot_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_sent_total     = sent_tot_ff;
   assign rsp_received_total = rcvd_tot_ff;

   // status back to the controller
   assign sts.used_zero = (used_ff == '0);
   assign sts.last_idx  = ((CNT_W'(idx_ff) + CNT_W'(1)) == used_ff);
   assign sts.key_match = (key_rd_ff == key_ff);
   assign sts.full      = (used_ff == CNT_W'(ENTRIES));
   assign sts.is_read   = is_read;

endmodule

@@ src/kbc_ctrl.sv @@
module kbc_ctrl
   import kbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  kbc_sts_type sts,
   output kbc_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_CMP  = 5'b00100,
      S_MISS = 5'b01000,
      S_ACC  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // response slot can take a word this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.res_kind = RES_MISS;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.used_zero ? S_MISS : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.key_match) begin
               state_in = S_ACC;
            end else if (sts.last_idx) begin
               state_in = S_MISS;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_READ;
            end
         end
         S_MISS: begin
            if (out_free) begin
               cmd.ld_rsp = 1'b1;
               state_in   = S_IDLE;
               if (sts.is_read) begin
                  cmd.res_kind = RES_MISS;
               end else if (sts.full) begin
                  cmd.res_kind = RES_FULL;
               end else begin
                  cmd.res_kind = RES_ALLOC;
                  cmd.alloc    = 1'b1;
               end
            end
         end
         S_ACC: begin
            if (out_free) begin
               cmd.ld_rsp   = 1'b1;
               cmd.res_kind = RES_HIT;
               cmd.update   = !sts.is_read;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/per_key_byte_counter_table_core.sv @@
// Per-user byte counter table. Each request word carries an opcode (add to sent,
// add to received, read; opcode 3 acts as a read), a 32-bit user key and a signed
// amount. Adds allocate the next free entry for an unknown key with both counters
// at zero; a full table answers status 1 and changes nothing, a read of an unknown
// key answers status 2; failures return zero totals. Entries are never freed and
// no clearing pass runs after reset: the fill count marks valid entries, so the
// block is ready as soon as reset drops. Lookup walks the key memory through its
// single read port, one entry at a time in a read state and a compare state, and
// stops at the first matching key; on an empty table the scan is skipped. A new
// request is taken once the response is loaded and the controller is back in idle.
// Up to one finished response waits in the output register while a new request
// is accepted.
module per_key_byte_counter_table_core
   import kbc_pkg::*;
#(
   parameter int ENTRIES = KBC_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   kbc_req_if.sink    req_chan,
   kbc_rsp_if.source  rsp_chan
);

   kbc_cmd_type cmd;
   kbc_sts_type sts;

   kbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kbc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_chan.opcode),
      .req_user_key       (req_chan.user_key),
      .req_byte_amount    (req_chan.byte_amount),
      .rsp_status         (rsp_chan.status),
      .rsp_sent_total     (rsp_chan.sent_total),
      .rsp_received_total (rsp_chan.received_total)
   );

`ifndef SYNTHESIS
   // never allocate past the end of the table
   a_no_alloc_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !sts.full)
      else $error("allocation with full table");

   // a response word is only loaded into a free output slot
   a_ld_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_rsp |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response overwritten while stalled");

   // one request at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while busy");
`endif

endmodule

@@ verif/per_key_byte_counter_table_core_test.sv @@
`timescale 1ns / 100ps

module per_key_byte_counter_table_core_test
   import kbc_pkg::*;
();

   // opcodes as the block decodes them; the last one falls into the read path
   localparam logic [OPCODE_W-1:0] OPC_ADD_SENT = 2'd0;
   localparam logic [OPCODE_W-1:0] OPC_ADD_RCVD = 2'd1;
   localparam logic [OPCODE_W-1:0] OPC_READ     = 2'd2;
   localparam logic [OPCODE_W-1:0] OPC_READ_ALT = 2'd3;

   localparam int DIR_N      = 16;
   localparam int RAND_N     = 1250;
   localparam int PAUSE_AT   = 600;   // sender waits here until all replies are back
   localparam int QUIET_N    = 150;   // last words run with no idling
   localparam int POOL_N     = 96;
   localparam int DRAIN_WAIT = 200;   // longer than a miss on a full table
   localparam int CYCLE_MAX  = 1000000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  sent;
      logic [TOTAL_W-1:0]  rcvd;
   } counter_reply_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    key;
      logic [AMOUNT_W-1:0] amt;
      logic                typed;   // reply below is fixed, else predicted
      counter_reply_type   reply;
   } dir_row_type;

   logic clock;
   logic reset;

   kbc_req_if req_bus ();
   kbc_rsp_if rsp_bus ();

   per_key_byte_counter_table_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predicted table contents
   logic [KEY_W-1:0]   tbl_key  [KBC_ENTRIES];
   logic               tbl_valid[KBC_ENTRIES];
   logic [TOTAL_W-1:0] tbl_sent [KBC_ENTRIES];
   logic [TOTAL_W-1:0] tbl_rcvd [KBC_ENTRIES];
   int                 tbl_used;

   counter_reply_type pending_replies[$];
   int                fail_count;
   int                cycle_count;
   bit                idle_on;
   int                ready_hold;

   logic [KEY_W-1:0] key_pool[POOL_N];
   dir_row_type      dir_rows[DIR_N];

   always #5 clock = ~clock;

   // apply one word to the predicted table and return the reply it earns
   function automatic counter_reply_type apply_to_table(logic [OPCODE_W-1:0] op,
                                                         logic [KEY_W-1:0] key,
                                                         logic [AMOUNT_W-1:0] amt);
      int                hit;
      counter_reply_type r;
      hit = -1;
      r.status = ST_OK;
      r.sent = '0;
      r.rcvd = '0;
      // lowest matching valid entry wins
      for (int i = 0; i < KBC_ENTRIES; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
      end
      if (op[OP_READ_BIT]) begin
         if (hit < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            r.sent = tbl_sent[hit];
            r.rcvd = tbl_rcvd[hit];
         end
         return r;
      end
      if (hit < 0) begin
         if (tbl_used >= KBC_ENTRIES) begin
            r.status = ST_FULL;
            return r;
         end
         hit = tbl_used;
         tbl_key[hit] = key;
         tbl_valid[hit] = 1'b1;
         tbl_sent[hit] = '0;
         tbl_rcvd[hit] = '0;
         tbl_used++;
      end
      if (op[OP_RCVD_BIT]) tbl_rcvd[hit] = tbl_rcvd[hit] + amt;
      else tbl_sent[hit] = tbl_sent[hit] + amt;
      r.sent = tbl_sent[hit];
      r.rcvd = tbl_rcvd[hit];
      return r;
   endfunction

   // drive one request word, wait for acceptance, queue what should come back
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [AMOUNT_W-1:0] amt, input logic typed,
                            input counter_reply_type fixed_reply);
      counter_reply_type predicted;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = op;
      req_bus.user_key = key;
      req_bus.byte_amount = amt;
      forever begin
         @(posedge clock);
         if (req_bus.valid && req_bus.ready) break;
      end
      predicted = apply_to_table(op, key, amt);
      pending_replies.push_back(typed ? fixed_reply : predicted);
   endtask

   // response side: ready drops in short random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
      end else if (ready_hold > 0) begin
         rsp_bus.ready = 1'b0;
         ready_hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready = 1'b0;
         ready_hold = $urandom_range(1, 4) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      counter_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response word status %0d sent %h rcvd %h", $time,
                     rsp_bus.status, rsp_bus.sent_total, rsp_bus.received_total);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.sent_total !== want.sent) begin
               $display("%0t: sent_total expected %h actual %h", $time, want.sent,
                        rsp_bus.sent_total);
               fail_count++;
            end
            if (rsp_bus.received_total !== want.rcvd) begin
               $display("%0t: received_total expected %h actual %h", $time, want.rcvd,
                        rsp_bus.received_total);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("[per_key_byte_counter_table_core] ERROR");
         $finish;
      end
   end

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    key;
      logic [AMOUNT_W-1:0] amt;
      int                  pick;
      int                  base;

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OPC_ADD_SENT;
      req_bus.user_key = '0;
      req_bus.byte_amount = '0;
      fail_count = 0;
      cycle_count = 0;
      ready_hold = 0;
      idle_on = 1'b1;
      tbl_used = 0;
      for (int i = 0; i < KBC_ENTRIES; i++) begin
         tbl_key[i] = '0;
         tbl_valid[i] = 1'b0;
         tbl_sent[i] = '0;
         tbl_rcvd[i] = '0;
      end

      // key pool: random keys, near misses one bit away, more random keys
      for (int i = 0; i < POOL_N; i++) begin
         if (i >= 32 && i < 64) key_pool[i] = key_pool[i-32] ^ (32'd1 << $urandom_range(0, 31));
         else key_pool[i] = $urandom;
      end

      // directed words: empty table, wrap at both ends, unused opcode, misses
      dir_rows = '{
         '{OPC_READ,     32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0}},
         '{OPC_READ_ALT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0}},
         '{OPC_ADD_SENT, 32'h0000_0000, 32'h7fff_ffff, 1'b1,
           '{ST_OK, 32'h7fff_ffff, 32'h0}},
         '{OPC_ADD_RCVD, 32'h0000_0000, 32'h8000_0000, 1'b1,
           '{ST_OK, 32'h7fff_ffff, 32'h8000_0000}},
         '{OPC_ADD_SENT, 32'h0000_0000, 32'h0000_0001, 1'b1,
           '{ST_OK, 32'h8000_0000, 32'h8000_0000}},
         '{OPC_ADD_SENT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{ST_OK, 32'hffff_ffff, 32'h0}},
         '{OPC_ADD_SENT, 32'hffff_ffff, 32'h0000_0001, 1'b1, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_ADD_RCVD, 32'hffff_ffff, 32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_READ,     32'h0000_0000, 32'hdead_beef, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_READ_ALT, 32'hffff_ffff, 32'h1234_5678, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_READ,     32'h5a5a_5a5a, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0}},
         '{OPC_ADD_RCVD, 32'ha5a5_a5a5, 32'hffff_ff00, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_ADD_SENT, 32'h0000_0001, 32'h8000_0000, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_ADD_SENT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_ADD_RCVD, 32'h8000_0000, 32'hffff_ffff, 1'b0, '{ST_OK, 32'h0, 32'h0}},
         '{OPC_READ,     32'h8000_0000, 32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 32'h0}}
      };

      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].amt, dir_rows[i].typed,
                   dir_rows[i].reply);

      // random words: mostly pool keys so hits, allocation and a full table all occur
      for (int n = 0; n < RAND_N; n++) begin
         if (n == PAUSE_AT) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
         if (n == RAND_N - QUIET_N) idle_on = 1'b0;

         pick = $urandom_range(0, 99);
         if (pick < 35) op = OPC_ADD_SENT;
         else if (pick < 70) op = OPC_ADD_RCVD;
         else if (pick < 90) op = OPC_READ;
         else op = OPC_READ_ALT;

         // later half leans on the near-miss and tail keys
         base = (n < PAUSE_AT) ? 0 : 32;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(base, POOL_N - 1)];
         else key = $urandom;

         pick = $urandom_range(0, 7);
         case (pick)
            0, 1: amt = $urandom_range(0, 1500);
            2: amt = -$urandom_range(1, 1500);
            3: begin
               case ($urandom_range(0, 3))
                  0: amt = 32'h8000_0000;
                  1: amt = 32'h7fff_ffff;
                  2: amt = 32'hffff_ffff;
                  default: amt = 32'h0000_0000;
               endcase
            end
            default: amt = $urandom;
         endcase

         send_word(op, key, amt, 1'b0, '0);
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) $display("[per_key_byte_counter_table_core] OK");
      else $display("[per_key_byte_counter_table_core] ERROR");
      $finish;
   end

endmodule
